### hw/rtl/cbc_pkg.sv
package cbc_pkg;

    // Bus command codes
    typedef enum logic [1:0] {
        CMD_ROM_READ   = 2'd0,
        CMD_CTRL_WRITE = 2'd1,
        CMD_RAM_READ   = 2'd2,
        CMD_RAM_WRITE  = 2'd3
    } cmd_t;

    // Where an access lands
    typedef enum logic [1:0] {
        TGT_OPEN = 2'd0,
        TGT_ROM  = 2'd1,
        TGT_RAM  = 2'd2,
        TGT_RTC  = 2'd3
    } target_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_ROM_SIZE_MASK = 2'd0,
        CFG_RAM_SIZE_CODE = 2'd1,
        CFG_RTC_PRESENT   = 2'd2,
        CFG_EXTENDED_MODE = 2'd3
    } cfg_index_t;

    // RAM size codes
    localparam logic [2:0] RAM_NONE = 3'd0;
    localparam logic [2:0] RAM_2K   = 3'd1;
    localparam logic [2:0] RAM_8K   = 3'd2;
    localparam logic [2:0] RAM_32K  = 3'd3;
    localparam logic [2:0] RAM_64K  = 3'd4;

    // Decoded operation handed from front to back
    typedef enum logic [2:0] {
        OP_ROM_LOW    = 3'd0,
        OP_ROM_BANKED = 3'd1,
        OP_NONE       = 3'd2,
        OP_RAM_ENABLE = 3'd3,
        OP_ROM_SELECT = 3'd4,
        OP_RAM_SELECT = 3'd5,
        OP_RAM_READ   = 3'd6,
        OP_RAM_WRITE  = 3'd7
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [15:0] address;
        logic [7:0]  data;
    } entry_t;

    typedef struct packed {
        logic [7:0] rom_size_mask;
        logic [2:0] ram_size_code;
        logic       rtc_present;
        logic       extended_mode;
    } cfg_t;

    typedef struct packed {
        target_t     target;
        logic [21:0] rom_address;
        logic [14:0] ram_address;
        logic [2:0]  rtc_index;
        logic        write_strobe;
        logic [7:0]  write_data;
        logic        accepted;
    } result_t;

    // Address map
    localparam logic [15:0] ROM_LOW_LAST     = 16'h3FFF;
    localparam logic [15:0] ROM_HIGH_LAST    = 16'h7FFF;
    localparam logic [15:0] CTRL_ENABLE_LAST = 16'h1FFF;
    localparam logic [15:0] CTRL_BANK_LAST   = 16'h3FFF;
    localparam logic [15:0] CTRL_SELECT_LAST = 16'h5FFF;
    localparam logic [15:0] RAM_LIMIT_SMALL  = 16'h07FF;
    localparam logic [15:0] RAM_LIMIT_FULL   = 16'h1FFF;
    localparam logic [3:0]  RAM_ENABLE_KEY   = 4'hA;

    localparam int ROM_BANK_BYTES = 16384;
    localparam int ROM_OFFSET_BITS = $clog2(ROM_BANK_BYTES);
    localparam int RAM_OFFSET_BITS = 13;

    localparam logic [7:0] ROM_MASK_NORMAL   = 8'h7F;
    localparam logic [7:0] ROM_MASK_EXTENDED = 8'hFF;
    localparam logic [7:0] ROM_ZERO_QUIRK    = 8'h60;
    localparam logic [7:0] RTC_SEL_FIRST     = 8'd8;
    localparam logic [7:0] RTC_SEL_LAST      = 8'd12;
    localparam logic [7:0] RESET_ROM_REQUEST = 8'd1;

    localparam logic [7:0] RESET_ROM_SIZE_MASK = 8'd127;

    // Front-to-back queue
    localparam int QUEUE_DEPTH    = 2;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    function automatic logic [7:0] rom_mode_mask(input logic extended_mode);
        return extended_mode ? ROM_MASK_EXTENDED : ROM_MASK_NORMAL;
    endfunction

    function automatic logic [3:0] ram_bank_count(input logic [2:0] code);
        logic [3:0] count;
        case (code)
            RAM_2K, RAM_8K: count = 4'd1;
            RAM_32K:        count = 4'd4;
            RAM_64K:        count = 4'd8;
            default:        count = 4'd0;
        endcase
        return count;
    endfunction

    function automatic logic [15:0] ram_limit(input logic [2:0] code);
        logic [15:0] limit;
        case (code)
            RAM_2K:                   limit = RAM_LIMIT_SMALL;
            RAM_8K, RAM_32K, RAM_64K: limit = RAM_LIMIT_FULL;
            default:                  limit = 16'h0000;
        endcase
        return limit;
    endfunction

    // RTC selects pass through; RAM selects are masked and clamped to the bank count
    function automatic logic [3:0] normalize_ram_bank(input logic [7:0] sel, input cfg_t cfg);
        logic [3:0] count;
        logic [3:0] masked;
        logic [3:0] bank;
        count  = ram_bank_count(cfg.ram_size_code);
        masked = cfg.extended_mode ? {1'b0, sel[2:0]} : {2'b00, sel[1:0]};
        if (sel >= RTC_SEL_FIRST && sel <= RTC_SEL_LAST)
        begin
            bank = sel[3:0];
        end
        else if (masked >= count)
        begin
            bank = (count != 4'd0) ? count - 4'd1 : 4'd0;
        end
        else
        begin
            bank = masked;
        end
        return bank;
    endfunction

endpackage

### hw/rtl/cbc_front.sv
module cbc_front (
    input  logic                 req_valid,
    output logic                 req_ready,
    input  logic [1:0]           cmd,
    input  logic [15:0]          address,
    input  logic [7:0]           data,
    input  logic                 push_ready,
    output logic                 push_valid,
    output cbc_pkg::entry_t      push_entry
);

    cbc_pkg::op_t op;

    // Decode the access into an operation for the back end
    always_comb
    begin
        case (cbc_pkg::cmd_t'(cmd))
            cbc_pkg::CMD_ROM_READ:
            begin
                if (address <= cbc_pkg::ROM_LOW_LAST)
                    op = cbc_pkg::OP_ROM_LOW;
                else if (address <= cbc_pkg::ROM_HIGH_LAST)
                    op = cbc_pkg::OP_ROM_BANKED;
                else
                    op = cbc_pkg::OP_NONE;
            end
            cbc_pkg::CMD_CTRL_WRITE:
            begin
                if (address <= cbc_pkg::CTRL_ENABLE_LAST)
                    op = cbc_pkg::OP_RAM_ENABLE;
                else if (address <= cbc_pkg::CTRL_BANK_LAST)
                    op = cbc_pkg::OP_ROM_SELECT;
                else if (address <= cbc_pkg::CTRL_SELECT_LAST)
                    op = cbc_pkg::OP_RAM_SELECT;
                else
                    op = cbc_pkg::OP_NONE;
            end
            cbc_pkg::CMD_RAM_READ:  op = cbc_pkg::OP_RAM_READ;
            cbc_pkg::CMD_RAM_WRITE: op = cbc_pkg::OP_RAM_WRITE;
            default:                op = cbc_pkg::OP_NONE;
        endcase
    end

    assign push_entry.op      = op;
    assign push_entry.address = address;
    assign push_entry.data    = data;
    assign push_valid         = req_valid;
    assign req_ready          = push_ready;

endmodule

### hw/rtl/cbc_queue.sv
module cbc_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push_valid,
    output logic                 push_ready,
    input  cbc_pkg::entry_t      push_entry,
    output logic                 pop_valid,
    input  logic                 pop_ready,
    output cbc_pkg::entry_t      pop_entry
);

    cbc_pkg::entry_t                     entries_reg [cbc_pkg::QUEUE_DEPTH];
    logic [cbc_pkg::QUEUE_PTR_BITS-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [cbc_pkg::QUEUE_PTR_BITS-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [cbc_pkg::QUEUE_CNT_BITS-1:0]  count_reg, count_next;
    logic                                do_push, do_pop;

    assign push_ready = (count_reg != cbc_pkg::QUEUE_CNT_BITS'(cbc_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = entries_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer and fill tracking
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == cbc_pkg::QUEUE_PTR_BITS'(cbc_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == cbc_pkg::QUEUE_PTR_BITS'(cbc_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            entries_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

### hw/rtl/cbc_back.sv
module cbc_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pop_valid,
    output logic                 pop_ready,
    input  cbc_pkg::entry_t      pop_entry,
    input  cbc_pkg::cfg_t        cfg,
    input  cbc_pkg::cfg_t        cfg_next,
    input  logic                 cfg_update,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output cbc_pkg::result_t     result
);

    logic             ram_enabled_reg, ram_enabled_next;
    logic [7:0]       rom_request_reg, rom_request_next;
    logic [7:0]       rom_bank_reg, rom_bank_next;
    logic [3:0]       ram_bank_reg, ram_bank_next;
    logic             out_valid_reg, out_valid_next;
    cbc_pkg::result_t result_reg, result_next;
    logic             do_pop;
    logic [7:0]       select_value;
    logic             ram_hit;
    logic             is_write;

    assign pop_ready = !out_valid_reg || rsp_ready;
    assign do_pop    = pop_valid && pop_ready;
    assign ram_hit   = ram_enabled_reg &&
                       (pop_entry.address <= cbc_pkg::ram_limit(cfg.ram_size_code));
    assign is_write  = (pop_entry.op == cbc_pkg::OP_RAM_WRITE);

    // ROM bank write: zero maps to one unless the current bank has bit 5 or 6 set
    always_comb
    begin
        select_value = pop_entry.data;
        if (pop_entry.data == 8'd0 && (rom_bank_reg & cbc_pkg::ROM_ZERO_QUIRK) == 8'd0)
            select_value = 8'd1;
    end

    // Execute one operation, or rebank after a configuration write
    always_comb
    begin
        ram_enabled_next = ram_enabled_reg;
        rom_request_next = rom_request_reg;
        rom_bank_next    = rom_bank_reg;
        ram_bank_next    = ram_bank_reg;
        result_next      = '0;
        result_next.target = cbc_pkg::TGT_OPEN;
        if (do_pop)
        begin
            case (pop_entry.op)
                cbc_pkg::OP_ROM_LOW:
                begin
                    result_next.target      = cbc_pkg::TGT_ROM;
                    result_next.rom_address =
                        {8'd0, pop_entry.address[cbc_pkg::ROM_OFFSET_BITS-1:0]};
                end
                cbc_pkg::OP_ROM_BANKED:
                begin
                    result_next.target      = cbc_pkg::TGT_ROM;
                    result_next.rom_address =
                        {rom_bank_reg, pop_entry.address[cbc_pkg::ROM_OFFSET_BITS-1:0]};
                end
                cbc_pkg::OP_RAM_ENABLE:
                begin
                    ram_enabled_next = (pop_entry.data[3:0] == cbc_pkg::RAM_ENABLE_KEY);
                end
                cbc_pkg::OP_ROM_SELECT:
                begin
                    rom_request_next = select_value & cbc_pkg::rom_mode_mask(cfg.extended_mode);
                    rom_bank_next    = rom_request_next
                                       & cbc_pkg::rom_mode_mask(cfg.extended_mode)
                                       & cfg.rom_size_mask;
                    ram_bank_next    = cbc_pkg::normalize_ram_bank({4'd0, ram_bank_reg}, cfg);
                end
                cbc_pkg::OP_RAM_SELECT:
                begin
                    ram_bank_next = cbc_pkg::normalize_ram_bank(pop_entry.data, cfg);
                end
                cbc_pkg::OP_RAM_READ, cbc_pkg::OP_RAM_WRITE:
                begin
                    if (ram_hit)
                    begin
                        if (is_write)
                        begin
                            result_next.accepted   = 1'b1;
                            result_next.write_data = pop_entry.data;
                        end
                        if (ram_bank_reg <= 4'd3)
                        begin
                            result_next.target       = cbc_pkg::TGT_RAM;
                            result_next.write_strobe = is_write;
                            if (cfg.ram_size_code inside {cbc_pkg::RAM_8K, cbc_pkg::RAM_32K,
                                                          cbc_pkg::RAM_64K})
                                result_next.ram_address =
                                    {ram_bank_reg[1:0],
                                     pop_entry.address[cbc_pkg::RAM_OFFSET_BITS-1:0]};
                            else
                                result_next.ram_address = pop_entry.address[14:0];
                        end
                        else if ({4'd0, ram_bank_reg} >= cbc_pkg::RTC_SEL_FIRST &&
                                 {4'd0, ram_bank_reg} <= cbc_pkg::RTC_SEL_LAST &&
                                 cfg.rtc_present)
                        begin
                            result_next.target       = cbc_pkg::TGT_RTC;
                            result_next.rtc_index    =
                                3'(ram_bank_reg - cbc_pkg::RTC_SEL_FIRST[3:0]);
                            result_next.write_strobe = is_write;
                        end
                    end
                end
                default:
                begin
                    result_next.target = cbc_pkg::TGT_OPEN;
                end
            endcase
        end
        else if (cfg_update)
        begin
            rom_bank_next = rom_request_reg
                            & cbc_pkg::rom_mode_mask(cfg_next.extended_mode)
                            & cfg_next.rom_size_mask;
            ram_bank_next = cbc_pkg::normalize_ram_bank({4'd0, ram_bank_reg}, cfg_next);
        end
    end

    // Output register handshake
    always_comb
    begin
        if (do_pop)
            out_valid_next = 1'b1;
        else if (rsp_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ram_enabled_reg <= 1'b0;
            rom_request_reg <= cbc_pkg::RESET_ROM_REQUEST;
            rom_bank_reg    <= cbc_pkg::RESET_ROM_REQUEST & cbc_pkg::RESET_ROM_SIZE_MASK;
            ram_bank_reg    <= 4'd0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            ram_enabled_reg <= ram_enabled_next;
            rom_request_reg <= rom_request_next;
            rom_bank_reg    <= rom_bank_next;
            ram_bank_reg    <= ram_bank_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_pop)
            result_reg <= result_next;
    end

    assign rsp_valid = out_valid_reg;
    assign result    = result_reg;

endmodule

### hw/rtl/cartridge_bank_controller.sv
// Cartridge bank controller: translates one cartridge bus access per transfer
// into a physical ROM address, a physical RAM address, an RTC register index,
// or open bus (target 0). Control writes to the ROM area set RAM enable, the
// ROM bank and the RAM/RTC select and return target 0. A front decoder feeds
// a two-entry queue and a back end holds the bank state and a registered
// result, so a request is taken every cycle while the response side keeps
// up; a result passes through the queue entry and then the result register
// before it is offered. The request side stalls only when the queue is full;
// with requests arriving back to back the queue holds one entry, so response
// backpressure fills it and the request side stalls from the next cycle.
// Configuration writes take effect at once and must only be issued with no
// request outstanding.
module cartridge_bank_controller (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_wdata,
    input  logic        req_valid,
    output logic        req_ready,
    input  logic [1:0]  cmd,
    input  logic [15:0] address,
    input  logic [7:0]  data,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output logic [1:0]  target,
    output logic [21:0] rom_address,
    output logic [14:0] ram_address,
    output logic [2:0]  rtc_index,
    output logic        write_strobe,
    output logic [7:0]  write_data,
    output logic        accepted
);

    cbc_pkg::cfg_t    cfg_reg, cfg_next;
    cbc_pkg::entry_t  push_entry, pop_entry;
    cbc_pkg::result_t result;
    logic             push_valid, push_ready;
    logic             pop_valid, pop_ready;

    // Configuration registers
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cbc_pkg::cfg_index_t'(cfg_index))
                cbc_pkg::CFG_ROM_SIZE_MASK: cfg_next.rom_size_mask = cfg_wdata;
                cbc_pkg::CFG_RAM_SIZE_CODE: cfg_next.ram_size_code = cfg_wdata[2:0];
                cbc_pkg::CFG_RTC_PRESENT:   cfg_next.rtc_present   = cfg_wdata[0];
                cbc_pkg::CFG_EXTENDED_MODE: cfg_next.extended_mode = cfg_wdata[0];
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rom_size_mask <= cbc_pkg::RESET_ROM_SIZE_MASK;
            cfg_reg.ram_size_code <= cbc_pkg::RAM_NONE;
            cfg_reg.rtc_present   <= 1'b0;
            cfg_reg.extended_mode <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    cbc_front u_front (
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .cmd        (cmd),
        .address    (address),
        .data       (data),
        .push_ready (push_ready),
        .push_valid (push_valid),
        .push_entry (push_entry)
    );

    cbc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    cbc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry),
        .cfg        (cfg_reg),
        .cfg_next   (cfg_next),
        .cfg_update (cfg_we),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .result     (result)
    );

    assign target       = result.target;
    assign rom_address  = result.rom_address;
    assign ram_address  = result.ram_address;
    assign rtc_index    = result.rtc_index;
    assign write_strobe = result.write_strobe;
    assign write_data   = result.write_data;
    assign accepted     = result.accepted;

    // A store strobe only goes to RAM or RTC
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && write_strobe |->
            (target == cbc_pkg::TGT_RAM || target == cbc_pkg::TGT_RTC))
        else $error("write strobe without RAM or RTC target");

    // A store strobe implies the write was accepted
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && write_strobe |-> accepted)
        else $error("write strobe on a write that was not accepted");

    // RTC index is only nonzero for RTC targets
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && target != cbc_pkg::TGT_RTC |-> rtc_index == 3'd0)
        else $error("RTC index set on a non-RTC result");

    // A stalled request side means the back end is holding a result
    assert property (@(posedge clk) disable iff (!rst_n)
        !req_ready |-> rsp_valid && pop_valid)
        else $error("request stall with nothing pending");

endmodule
